[rtl/core/msp_pkg.sv]
// shared constants and types for the multi-stack shared pool
package msp_pkg;

    localparam int NUM_STACKS = 4;
    localparam int NUM_SLOTS  = 16;

    localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LINK_W  = $clog2(NUM_SLOTS + 1);
    localparam int STACK_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

    localparam int SN_W       = 2;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int CMD_W      = 1;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    typedef logic [LINK_W-1:0]  link_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [VALUE_W-1:0] value_t;

    localparam link_t LINK_NULL = LINK_W'(NUM_SLOTS);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

endpackage

[rtl/core/msp_ram.sv]
// generic single-port-write ram with registered read
module msp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/multi_stack_shared_pool.sv]
// several linked stacks sharing one slot pool with a free list
// an accepted word is registered with its slot index, then handled in EXEC, which
// registers the result; no word is accepted in EXEC, which uses the index lookup
//   and the registered link and data reads for that slot, or while the output stalls
// reset: synchronous active low; all stacks empty, the free list chains every slot
//   through per-slot link valid flags, so no clearing pass; slot data is not cleared
module multi_stack_shared_pool (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // stack_number [1:0], push_value [33:2], zero [39:34]
    input  logic [msp_pkg::IN_DATA_W-1:0]   s_tdata,
    // command [0]
    input  logic [msp_pkg::CMD_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pop_value [31:0]
    output logic [msp_pkg::OUT_DATA_W-1:0]  m_tdata,
    // status [1:0]
    output logic [msp_pkg::STATUS_W-1:0]    m_tuser
);
    import msp_pkg::*;

    typedef enum logic {
        IDLE,
        EXEC
    } state_t;

    state_t          state_reg, state_next;
    cmd_t            cmd_reg, cmd_next;
    logic [SN_W-1:0] sn_reg, sn_next;
    value_t          value_reg, value_next;
    link_t           idx_reg, idx_next;
    link_t           stack_top_reg [NUM_STACKS];
    link_t           stack_top_next [NUM_STACKS];
    link_t           free_head_reg, free_head_next;
    logic            link_vld_reg [NUM_SLOTS];
    logic            link_vld_next [NUM_SLOTS];
    logic            m_valid_reg, m_valid_next;
    status_t         m_status_reg, m_status_next;
    value_t          m_value_reg, m_value_next;

    logic [SN_W-1:0] in_sn;
    cmd_t            in_cmd;
    logic            in_sn_ok;
    link_t           in_idx;
    logic            accept;

    logic            idx_ok;
    slot_t           slot;
    logic [STACK_W-1:0] sn_idx;
    link_t           link_q;
    link_t           link_rd;
    value_t          data_q;
    logic            data_we;
    logic            link_we;
    link_t           link_wdata;

    assign in_sn    = s_tdata[SN_W-1:0];
    assign in_cmd   = cmd_t'(s_tuser);
    assign in_sn_ok = (32'(in_sn) < NUM_STACKS);

    // slot addressed by this word: free head for push, stack top for pop
    always_comb begin
        if (!in_sn_ok) begin
            in_idx = LINK_NULL;
        end else if (in_cmd == CMD_PUSH) begin
            in_idx = free_head_reg;
        end else begin
            in_idx = stack_top_reg[STACK_W'(in_sn)];
        end
    end

    assign s_tready = (state_reg == IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign idx_ok = (idx_reg < LINK_NULL);
    assign slot   = idx_reg[SLOT_W-1:0];
    assign sn_idx = STACK_W'(sn_reg);

    // a link never written still holds its reset chain value
    assign link_rd = link_vld_reg[slot] ? link_q : (LINK_W'(slot) + LINK_W'(1));

    assign data_we    = (state_reg == EXEC) && (cmd_reg == CMD_PUSH) && idx_ok;
    assign link_we    = (state_reg == EXEC) && idx_ok;
    assign link_wdata = (cmd_reg == CMD_PUSH) ? stack_top_reg[sn_idx] : free_head_reg;

    msp_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (NUM_SLOTS)
    ) u_data_ram (
        .aclk  (aclk),
        .we    (data_we),
        .waddr (slot),
        .wdata (value_reg),
        .raddr (in_idx[SLOT_W-1:0]),
        .rdata (data_q)
    );

    msp_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_SLOTS)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (slot),
        .wdata (link_wdata),
        .raddr (in_idx[SLOT_W-1:0]),
        .rdata (link_q)
    );

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        sn_next        = sn_reg;
        value_next     = value_reg;
        idx_next       = idx_reg;
        stack_top_next = stack_top_reg;
        free_head_next = free_head_reg;
        link_vld_next  = link_vld_reg;
        m_valid_next   = m_valid_reg;
        m_status_next  = m_status_reg;
        m_value_next   = m_value_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            IDLE: begin
                if (accept) begin
                    cmd_next   = in_cmd;
                    sn_next    = in_sn;
                    value_next = s_tdata[SN_W +: VALUE_W];
                    idx_next   = in_idx;
                    state_next = EXEC;
                end
            end
            EXEC: begin
                m_valid_next = 1'b1;
                m_value_next = '0;
                state_next   = IDLE;
                if (!idx_ok) begin
                    m_status_next = (cmd_reg == CMD_PUSH) ? ST_OVERFLOW : ST_UNDERFLOW;
                end else begin
                    m_status_next       = ST_DONE;
                    link_vld_next[slot] = 1'b1;
                    if (cmd_reg == CMD_PUSH) begin
                        free_head_next         = link_rd;
                        stack_top_next[sn_idx] = idx_reg;
                    end else begin
                        stack_top_next[sn_idx] = link_rd;
                        free_head_next         = idx_reg;
                        m_value_next           = data_q;
                    end
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            free_head_reg <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_STACKS; i++) begin
                stack_top_reg[i] <= LINK_NULL;
            end
            for (int i = 0; i < NUM_SLOTS; i++) begin
                link_vld_reg[i] <= 1'b0;
            end
        end else begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            m_valid_reg   <= m_valid_next;
            stack_top_reg <= stack_top_next;
            link_vld_reg  <= link_vld_next;
        end
        cmd_reg      <= cmd_next;
        sn_reg       <= sn_next;
        value_reg    <= value_next;
        idx_reg      <= idx_next;
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_status_reg;

endmodule
